/* src/qoe_pkg.sv */
// ----------------------------------------------------------------------------
// qoe_pkg
// Shared widths, arctangent table and payload types of the orientation error
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qoe_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int IN_W     = 16;
  localparam int PROD_W   = 2 * IN_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int MAG_W    = 25;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int RAD_W    = 52;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 4;
  localparam int LIMIT_W  = 10;
  localparam int NORM_W   = ROOT_W + 14;
  localparam int CORDIC_W = 28;
  localparam int ANGLE_W  = 34;
  localparam int ZMAG_W   = 31;
  localparam int SPROD_W  = ZMAG_W + MAG_W;
  localparam int DEN_W    = ROOT_W + 18;
  localparam int NUM_W    = 60;
  localparam int QUO_W    = 16;
  localparam int OUT_W    = 16;

  // atan(2^-i) in Q30 radians, truncated
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [IN_W-1:0] desired_w;
    logic signed [IN_W-1:0] desired_x;
    logic signed [IN_W-1:0] desired_y;
    logic signed [IN_W-1:0] desired_z;
    logic signed [IN_W-1:0] current_w;
    logic signed [IN_W-1:0] current_x;
    logic signed [IN_W-1:0] current_y;
    logic signed [IN_W-1:0] current_z;
  } in_data_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] error_x;
    logic signed [OUT_W-1:0] error_y;
    logic signed [OUT_W-1:0] error_z;
    logic                    below_limit;
  } out_data_t;

  // folded error quaternion as magnitudes plus signs of the vector part
  typedef struct packed {
    logic [3:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } vec_t;

  typedef struct packed {
    vec_t              vec;
    logic [ROOT_W-1:0] sv;
    logic              below;
  } cside_t;

endpackage

`default_nettype wire

/* src/qoe_front.sv */
// ----------------------------------------------------------------------------
// qoe_front
// Quaternion product, rounding to Q20, sign fold and squared norms.
// ----------------------------------------------------------------------------
`default_nettype none

module qoe_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire qoe_pkg::in_data_t           in_data,
  output logic                             out_valid,
  output logic [qoe_pkg::RAD_W-1:0]        out_vv,
  output logic [qoe_pkg::RAD_W-1:0]        out_qq,
  output qoe_pkg::vec_t                    out_vec
);

  localparam int PROD_W = qoe_pkg::PROD_W;
  localparam int SUM_W  = qoe_pkg::SUM_W;
  localparam int MAG_W  = qoe_pkg::MAG_W;
  localparam int SQR_W  = qoe_pkg::SQR_W;
  localparam int RAD_W  = qoe_pkg::RAD_W;

  // returns {negative, magnitude} of a Q28 sum rounded half away to Q20
  function automatic logic [MAG_W:0] round_q20(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] r;
    a = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    r = (a + SUM_W'(128)) >> 8;
    return {s[SUM_W-1] && (r[MAG_W-1:0] != '0), r[MAG_W-1:0]};
  endfunction

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [PROD_W-1:0] p_r   [16];
  logic signed [PROD_W-1:0] p_nxt [16];
  qoe_pkg::vec_t            vec2_r, vec2_nxt, vec3_r, vec4_r;
  logic [SQR_W-1:0]         sq3_r [4];
  logic [RAD_W-1:0]         vv4_r, qq4_r;
  logic signed [SUM_W-1:0]  s [4];
  logic [MAG_W:0]           rq [4];

  always_comb begin
    p_nxt[0]  = PROD_W'(in_data.desired_w) * PROD_W'(in_data.current_w);
    p_nxt[1]  = PROD_W'(in_data.desired_x) * PROD_W'(in_data.current_x);
    p_nxt[2]  = PROD_W'(in_data.desired_y) * PROD_W'(in_data.current_y);
    p_nxt[3]  = PROD_W'(in_data.desired_z) * PROD_W'(in_data.current_z);
    p_nxt[4]  = PROD_W'(in_data.current_w) * PROD_W'(in_data.desired_x);
    p_nxt[5]  = PROD_W'(in_data.desired_w) * PROD_W'(in_data.current_x);
    p_nxt[6]  = PROD_W'(in_data.desired_y) * PROD_W'(in_data.current_z);
    p_nxt[7]  = PROD_W'(in_data.desired_z) * PROD_W'(in_data.current_y);
    p_nxt[8]  = PROD_W'(in_data.current_w) * PROD_W'(in_data.desired_y);
    p_nxt[9]  = PROD_W'(in_data.desired_w) * PROD_W'(in_data.current_y);
    p_nxt[10] = PROD_W'(in_data.desired_z) * PROD_W'(in_data.current_x);
    p_nxt[11] = PROD_W'(in_data.desired_x) * PROD_W'(in_data.current_z);
    p_nxt[12] = PROD_W'(in_data.current_w) * PROD_W'(in_data.desired_z);
    p_nxt[13] = PROD_W'(in_data.desired_w) * PROD_W'(in_data.current_z);
    p_nxt[14] = PROD_W'(in_data.desired_x) * PROD_W'(in_data.current_y);
    p_nxt[15] = PROD_W'(in_data.desired_y) * PROD_W'(in_data.current_x);
  end

  always_comb begin
    s[0] = SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]) + SUM_W'(p_r[3]);
    s[1] = SUM_W'(p_r[4]) - SUM_W'(p_r[5]) - SUM_W'(p_r[6]) + SUM_W'(p_r[7]);
    s[2] = SUM_W'(p_r[8]) - SUM_W'(p_r[9]) - SUM_W'(p_r[10]) + SUM_W'(p_r[11]);
    s[3] = SUM_W'(p_r[12]) - SUM_W'(p_r[13]) - SUM_W'(p_r[14]) + SUM_W'(p_r[15]);
    for (int i = 0; i < 4; i++) begin
      rq[i] = round_q20(s[i]);
      vec2_nxt.mag[i] = rq[i][MAG_W-1:0];
    end
    // negative scalar part flips every sign
    for (int i = 0; i < 3; i++) begin
      vec2_nxt.neg[i] = (rq[i+1][MAG_W-1:0] != '0) && (rq[i+1][MAG_W] ^ rq[0][MAG_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    vec2_r <= vec2_nxt;
    vec3_r <= vec2_r;
    vec4_r <= vec3_r;
    for (int i = 0; i < 4; i++) begin
      sq3_r[i] <= SQR_W'(vec2_r.mag[i]) * SQR_W'(vec2_r.mag[i]);
    end
    vv4_r <= RAD_W'(sq3_r[1]) + RAD_W'(sq3_r[2]) + RAD_W'(sq3_r[3]);
    qq4_r <= RAD_W'(sq3_r[0]) + RAD_W'(sq3_r[1]) + RAD_W'(sq3_r[2]) + RAD_W'(sq3_r[3]);
  end

  assign out_valid = v4_r;
  assign out_vv    = vv4_r;
  assign out_qq    = qq4_r;
  assign out_vec   = vec4_r;

endmodule

`default_nettype wire

/* src/qoe_isqrt.sv */
// ----------------------------------------------------------------------------
// qoe_isqrt
// Two-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qoe_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [qoe_pkg::RAD_W-1:0]    in_vv,
  input  wire logic [qoe_pkg::RAD_W-1:0]    in_qq,
  input  wire qoe_pkg::vec_t                in_vec,
  output logic                              out_valid,
  output logic [qoe_pkg::ROOT_W-1:0]        out_sv,
  output logic [qoe_pkg::ROOT_W-1:0]        out_sq,
  output qoe_pkg::vec_t                     out_vec
);

  localparam int RAD_W  = qoe_pkg::RAD_W;
  localparam int ROOT_W = qoe_pkg::ROOT_W;
  localparam int REM_W  = qoe_pkg::REM_W;

  logic                   valid [ROOT_W+1];
  logic [1:0][RAD_W-1:0]  rad   [ROOT_W+1];
  logic [1:0][REM_W-1:0]  rem   [ROOT_W+1];
  logic [1:0][ROOT_W-1:0] root  [ROOT_W+1];
  qoe_pkg::vec_t          vec   [ROOT_W+1];

  assign valid[0] = in_valid;
  assign rad[0]   = {in_qq, in_vv};
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign vec[0]   = in_vec;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [1:0][REM_W-1:0]  cur, trial, rem_nxt;
    logic [1:0][ROOT_W-1:0] root_nxt;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        cur[l]   = {rem[s][l][REM_W-3:0], rad[s][l][RAD_W-1-2*s -: 2]};
        trial[l] = REM_W'({root[s][l], 2'b01});
        if (cur[l] >= trial[l]) begin
          rem_nxt[l]  = cur[l] - trial[l];
          root_nxt[l] = {root[s][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = cur[l];
          root_nxt[l] = {root[s][l][ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      rad[s+1]  <= rad[s];
      rem[s+1]  <= rem_nxt;
      root[s+1] <= root_nxt;
      vec[s+1]  <= vec[s];
    end
  end

  assign out_valid = valid[ROOT_W];
  assign out_sv    = root[ROOT_W][0];
  assign out_sq    = root[ROOT_W][1];
  assign out_vec   = vec[ROOT_W];

endmodule

`default_nettype wire

/* src/qoe_cordic.sv */
// ----------------------------------------------------------------------------
// qoe_cordic
// Unrolled vectoring CORDIC, one micro-rotation per stage, angle in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module qoe_cordic #(
  parameter int ITERATIONS = qoe_pkg::CORDIC_ITERATIONS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic signed [qoe_pkg::CORDIC_W-1:0] in_x,
  input  wire logic signed [qoe_pkg::CORDIC_W-1:0] in_y,
  input  wire qoe_pkg::cside_t                     in_side,
  output logic                                     out_valid,
  output logic signed [qoe_pkg::ANGLE_W-1:0]       out_z,
  output qoe_pkg::cside_t                          out_side
);

  localparam int CORDIC_W = qoe_pkg::CORDIC_W;
  localparam int ANGLE_W  = qoe_pkg::ANGLE_W;
  localparam int NST = (ITERATIONS < qoe_pkg::ATAN_ENTRIES) ? ITERATIONS
                                                            : qoe_pkg::ATAN_ENTRIES;

  logic                       valid [NST+1];
  logic signed [CORDIC_W-1:0] x     [NST+1];
  logic signed [CORDIC_W-1:0] y     [NST+1];
  logic signed [ANGLE_W-1:0]  z     [NST+1];
  qoe_pkg::cside_t            side  [NST+1];

  assign valid[0] = in_valid;
  assign x[0]     = in_x;
  assign y[0]     = in_y;
  assign z[0]     = '0;
  assign side[0]  = in_side;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam logic signed [ANGLE_W-1:0] ATAN = ANGLE_W'(qoe_pkg::ATAN_Q30[s]);
    logic signed [CORDIC_W-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ANGLE_W-1:0]  z_nxt;

    always_comb begin
      xs = x[s] >>> s;
      ys = y[s] >>> s;
      // rotate toward the x axis
      if (!y[s][CORDIC_W-1] && (y[s] != '0)) begin
        x_nxt = x[s] + ys;
        y_nxt = y[s] - xs;
        z_nxt = z[s] + ATAN;
      end else begin
        x_nxt = x[s] - ys;
        y_nxt = y[s] + xs;
        z_nxt = z[s] - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
    end

    always_ff @(posedge clk) begin
      x[s+1]    <= x_nxt;
      y[s+1]    <= y_nxt;
      z[s+1]    <= z_nxt;
      side[s+1] <= side[s];
    end
  end

  assign out_valid = valid[NST];
  assign out_z     = z[NST];
  assign out_side  = side[NST];

endmodule

`default_nettype wire

/* src/qoe_scale.sv */
// ----------------------------------------------------------------------------
// qoe_scale
// Angle times unit vector: three-lane rounded restoring divide, sign and
// saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qoe_scale (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic signed [qoe_pkg::ANGLE_W-1:0] in_z,
  input  wire qoe_pkg::cside_t                    in_side,
  output logic                                    out_valid,
  output qoe_pkg::out_data_t                      out_data
);

  localparam int ANGLE_W = qoe_pkg::ANGLE_W;
  localparam int ZMAG_W  = qoe_pkg::ZMAG_W;
  localparam int SPROD_W = qoe_pkg::SPROD_W;
  localparam int DEN_W   = qoe_pkg::DEN_W;
  localparam int NUM_W   = qoe_pkg::NUM_W;
  localparam int QUO_W   = qoe_pkg::QUO_W;
  localparam int OUT_W   = qoe_pkg::OUT_W;
  localparam int ROOT_W  = qoe_pkg::ROOT_W;
  localparam int SV_W    = QUO_W + 2;

  typedef struct packed {
    logic [2:0] neg;
    logic       below;
  } tag_t;

  // multiply stage
  logic                     m_valid_r;
  logic [2:0][SPROD_W-1:0]  m_prod_r, m_prod_nxt;
  logic [ROOT_W-1:0]        m_sv_r;
  tag_t                     m_tag_r;
  logic [ZMAG_W-1:0]        zc;

  always_comb begin
    // negative final angle counts as zero
    zc = in_z[ANGLE_W-1] ? '0 : in_z[ZMAG_W-1:0];
    for (int i = 0; i < 3; i++) begin
      m_prod_nxt[i] = SPROD_W'(zc) * SPROD_W'(in_side.vec.mag[i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_prod_r      <= m_prod_nxt;
    m_sv_r        <= in_side.sv;
    m_tag_r.neg   <= in_side.vec.neg;
    m_tag_r.below <= in_side.below;
  end

  // divide stages
  logic                    valid [QUO_W+1];
  logic [2:0][NUM_W-1:0]   rem   [QUO_W+1];
  logic [2:0][QUO_W-1:0]   quo   [QUO_W+1];
  logic [DEN_W-1:0]        den   [QUO_W+1];
  tag_t                    tag   [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= m_valid_r;
    end
  end

  // numerator carries the half divisor for rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= (NUM_W'(m_prod_r[i]) << 1) + (NUM_W'(m_sv_r) << 17);
    end
    quo[0] <= '0;
    den[0] <= DEN_W'(m_sv_r) << 18;
    tag[0] <= m_tag_r;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [NUM_W-1:0]      dk;
    logic [2:0][NUM_W-1:0] rem_nxt;
    logic [2:0][QUO_W-1:0] quo_nxt;

    always_comb begin
      dk = NUM_W'(den[k]) << (QUO_W - 1 - k);
      for (int i = 0; i < 3; i++) begin
        if (rem[k][i] >= dk) begin
          rem_nxt[i] = rem[k][i] - dk;
          quo_nxt[i] = {quo[k][i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = rem[k][i];
          quo_nxt[i] = {quo[k][i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= rem_nxt;
      quo[k+1] <= quo_nxt;
      den[k+1] <= den[k];
      tag[k+1] <= tag[k];
    end
  end

  // sign, saturation, zero on small norm
  logic                       out_valid_r;
  qoe_pkg::out_data_t         out_data_r, out_data_nxt;
  logic signed [SV_W-1:0]     qs   [3];
  logic signed [SV_W-1:0]     sval [3];
  logic signed [OUT_W-1:0]    sat  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i]   = SV_W'(quo[QUO_W][i]);
      sval[i] = tag[QUO_W].neg[i] ? qs[i] : -qs[i];
      if (sval[i] > SV_W'(2**(OUT_W-1) - 1)) begin
        sat[i] = OUT_W'(2**(OUT_W-1) - 1);
      end else if (sval[i] < -SV_W'(2**(OUT_W-1))) begin
        sat[i] = OUT_W'(-(2**(OUT_W-1)));
      end else begin
        sat[i] = sval[i][OUT_W-1:0];
      end
    end
    if (tag[QUO_W].below) begin
      out_data_nxt = '{error_x: '0, error_y: '0, error_z: '0, below_limit: 1'b1};
    end else begin
      out_data_nxt = '{error_x: sat[0], error_y: sat[1], error_z: sat[2],
                       below_limit: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/quaternion_orientation_error.sv */
// ----------------------------------------------------------------------------
// quaternion_orientation_error
// Rotation vector of the error between a desired and a current quaternion.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  input     start, busy, in_data           start & !busy
//  result    out_valid, out_data            one-cycle strobe, no backpressure
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid & cfg_ready
//
//  one item per cycle while busy is low
//  the pipeline holds the 26-bit square root (one bit per stage), the cordic
//  (one rotation per stage) and the 16-bit quotient divider (one bit per stage)
//  synchronous reset clears the pipeline valid bits and the limit register
//  busy is high only during reset and the cycle after it
//
`default_nettype none

module quaternion_orientation_error #(
  parameter int CORDIC_ITERATIONS = qoe_pkg::CORDIC_ITERATIONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire qoe_pkg::in_data_t             in_data,
  output logic                               out_valid,
  output qoe_pkg::out_data_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [qoe_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int RAD_W    = qoe_pkg::RAD_W;
  localparam int ROOT_W   = qoe_pkg::ROOT_W;
  localparam int LIMIT_W  = qoe_pkg::LIMIT_W;
  localparam int NORM_W   = qoe_pkg::NORM_W;
  localparam int CORDIC_W = qoe_pkg::CORDIC_W;
  localparam int NST = (CORDIC_ITERATIONS < qoe_pkg::ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                                   : qoe_pkg::ATAN_ENTRIES;
  localparam int LATENCY = 4 + ROOT_W + 2 + NST + qoe_pkg::QUO_W + 3;

  logic               rdy_r;
  logic [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r   <= 1'b0;
      limit_r <= '0;
    end else begin
      rdy_r <= 1'b1;
      if (cfg_valid && rdy_r) begin
        limit_r <= cfg_data;
      end
    end
  end

  assign busy      = ~rdy_r;
  assign cfg_ready = rdy_r;

  logic              f_valid;
  logic [RAD_W-1:0]  f_vv, f_qq;
  qoe_pkg::vec_t     f_vec;

  qoe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && rdy_r),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_vv    (f_vv),
    .out_qq    (f_qq),
    .out_vec   (f_vec)
  );

  logic              r_valid;
  logic [ROOT_W-1:0] r_sv, r_sq;
  qoe_pkg::vec_t     r_vec;

  qoe_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_vv     (f_vv),
    .in_qq     (f_qq),
    .in_vec    (f_vec),
    .out_valid (r_valid),
    .out_sv    (r_sv),
    .out_sq    (r_sq),
    .out_vec   (r_vec)
  );

  // norm ratio test: floor(sv*2^14/sq) <= limit  <=>  sv*2^14 < (limit+1)*sq
  logic              l1_valid_r, l2_valid_r;
  logic [NORM_W-1:0] l1_prod_r;
  logic [ROOT_W-1:0] l1_sv_r;
  logic              l1_zero_r;
  qoe_pkg::vec_t     l1_vec_r;
  qoe_pkg::cside_t   l2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_valid_r <= 1'b0;
      l2_valid_r <= 1'b0;
    end else begin
      l1_valid_r <= r_valid;
      l2_valid_r <= l1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    l1_prod_r       <= (NORM_W'(limit_r) + NORM_W'(1)) * NORM_W'(r_sq);
    l1_sv_r         <= r_sv;
    l1_zero_r       <= (r_sv == '0) || (r_sq == '0);
    l1_vec_r        <= r_vec;
    l2_side_r.vec   <= l1_vec_r;
    l2_side_r.sv    <= l1_sv_r;
    l2_side_r.below <= l1_zero_r || ({l1_sv_r, 14'b0} < l1_prod_r);
  end

  logic                                c_valid;
  logic signed [qoe_pkg::ANGLE_W-1:0]  c_z;
  qoe_pkg::cside_t                     c_side;

  qoe_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l2_valid_r),
    .in_x      (CORDIC_W'(l2_side_r.vec.mag[0])),
    .in_y      (CORDIC_W'(l2_side_r.sv)),
    .in_side   (l2_side_r),
    .out_valid (c_valid),
    .out_z     (c_z),
    .out_side  (c_side)
  );

  qoe_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_z      (c_z),
    .in_side   (c_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted word did not produce a result");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  a_below_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.below_limit) |->
      (out_data.error_x == '0 && out_data.error_y == '0 && out_data.error_z == '0))
    else $error("small norm result not zero");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (limit_r == $past(cfg_data)))
    else $error("limit register not written");
`endif

endmodule

`default_nettype wire

/* tb/tb_quaternion_orientation_error.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_orientation_error
// Self-checking bench for the quaternion orientation error pipeline: a short
// table of hand-picked quaternion pairs, then random pairs, most of them close
// together, under several small_norm_limit settings. Each result is checked
// field by field against a table row or a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_orientation_error;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 4 + 26 + 2 + qoe_pkg::CORDIC_ITERATIONS + 19;
  localparam int IDLE_MAX  = 4000;
  localparam int N_RANDOM  = 1200;
  localparam int ROTATIONS = (qoe_pkg::CORDIC_ITERATIONS < 24) ? qoe_pkg::CORDIC_ITERATIONS
                                                               : 24;
  localparam int LIMIT_W   = qoe_pkg::LIMIT_W;
  localparam int OUT_W     = qoe_pkg::OUT_W;

  localparam longint ARCTAN [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  qoe_pkg::in_data_t    in_data;
  logic                 out_valid;
  qoe_pkg::out_data_t   out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  quaternion_orientation_error uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  logic [LIMIT_W-1:0]  norm_limit;
  qoe_pkg::out_data_t  pending_errors [$];
  int                  fail_count;
  int                  words_sent;
  int                  words_checked;
  int                  below_count;
  int                  idle_cycles;
  bit                  no_gaps;

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_q20(longint v);
    if (v >= 0) return (v + 128) >>> 8;
    return -((-v + 128) >>> 8);
  endfunction

  function automatic qoe_pkg::out_data_t rotation_error(qoe_pkg::in_data_t d,
                                                        logic [LIMIT_W-1:0] lim);
    longint dw, dx, dy, dz, cw, cx, cy, cz;
    longint e [4];
    longint unsigned vv, qq, sv, sq, mag, num, den;
    longint x, y, z, xs, ys, q, r;
    logic signed [OUT_W-1:0] res [3];
    qoe_pkg::out_data_t o;
    dw = d.desired_w; dx = d.desired_x; dy = d.desired_y; dz = d.desired_z;
    cw = d.current_w; cx = d.current_x; cy = d.current_y; cz = d.current_z;
    e[0] = round_q20(dw * cw + dx * cx + dy * cy + dz * cz);
    e[1] = round_q20(cw * dx - dw * cx - dy * cz + dz * cy);
    e[2] = round_q20(cw * dy - dw * cy - dz * cx + dx * cz);
    e[3] = round_q20(cw * dz - dw * cz - dx * cy + dy * cx);
    // keep the short way round
    if (e[0] < 0)
      for (int i = 0; i < 4; i++) e[i] = -e[i];
    vv = e[1] * e[1] + e[2] * e[2] + e[3] * e[3];
    qq = vv + e[0] * e[0];
    sv = int_sqrt(vv);
    sq = int_sqrt(qq);
    o = '0;
    if (sv == 0 || sq == 0 || ((sv << 14) / sq) <= lim) begin
      o.below_limit = 1'b1;
      return o;
    end
    x = e[0];
    y = sv;
    z = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ARCTAN[i];
      end else begin
        x -= ys; y += xs; z -= ARCTAN[i];
      end
    end
    if (z < 0) z = 0;
    den = sv << 18;
    for (int i = 1; i < 4; i++) begin
      mag = (e[i] < 0) ? -e[i] : e[i];
      num = 2 * z * mag;
      q = (num + den / 2) / den;
      r = (e[i] < 0) ? q : -q;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res[i-1] = r[OUT_W-1:0];
    end
    o.error_x = res[0];
    o.error_y = res[1];
    o.error_z = res[2];
    return o;
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    qoe_pkg::out_data_t want;
    if (out_valid) begin
      if (pending_errors.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_errors.pop_front();
        words_checked++;
        if (out_data.below_limit) below_count++;
        if (out_data.error_x !== want.error_x) begin
          $display("%0t: error_x expected %0d got %0d", $time, want.error_x, out_data.error_x);
          fail_count++;
        end
        if (out_data.error_y !== want.error_y) begin
          $display("%0t: error_y expected %0d got %0d", $time, want.error_y, out_data.error_y);
          fail_count++;
        end
        if (out_data.error_z !== want.error_z) begin
          $display("%0t: error_z expected %0d got %0d", $time, want.error_z, out_data.error_z);
          fail_count++;
        end
        if (out_data.below_limit !== want.below_limit) begin
          $display("%0t: below_limit expected %0b got %0b", $time, want.below_limit,
                   out_data.below_limit);
          fail_count++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted word, result or config write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_errors.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic pick_gap();
    int g;
    int sel;
    sel = $urandom_range(0, 19);
    if (no_gaps || sel < 12) g = 0;
    else if (sel < 18) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // exp_known: expectation typed in the table rather than predicted
  task automatic send_pair(qoe_pkg::in_data_t d, bit exp_known, qoe_pkg::out_data_t exp_word);
    start   <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_errors.push_back(exp_known ? exp_word : rotation_error(d, norm_limit));
    words_sent++;
    pick_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_errors.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    norm_limit = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic qoe_pkg::in_data_t random_pair();
    qoe_pkg::in_data_t d;
    int sel;
    int spread;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      d = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else if (sel < 8) begin
      d.desired_w = 16'($urandom_range(0, 32767) - 16384);
      d.desired_x = 16'($urandom_range(0, 32767) - 16384);
      d.desired_y = 16'($urandom_range(0, 32767) - 16384);
      d.desired_z = 16'($urandom_range(0, 32767) - 16384);
      d.current_w = 16'($urandom_range(0, 32767) - 16384);
      d.current_x = 16'($urandom_range(0, 32767) - 16384);
      d.current_y = 16'($urandom_range(0, 32767) - 16384);
      d.current_z = 16'($urandom_range(0, 32767) - 16384);
    end else begin
      // nearby orientations, straddling the norm limit
      case ($urandom_range(0, 3))
        0: spread = $urandom_range(0, 3);
        1: spread = $urandom_range(4, 60);
        2: spread = $urandom_range(61, 1500);
        default: spread = $urandom_range(1501, 9000);
      endcase
      d.desired_w = 16'($urandom_range(0, 24000) - 12000);
      d.desired_x = 16'($urandom_range(0, 24000) - 12000);
      d.desired_y = 16'($urandom_range(0, 24000) - 12000);
      d.desired_z = 16'($urandom_range(0, 24000) - 12000);
      d.current_w = clip16(int'(d.desired_w) + $urandom_range(0, 2 * spread) - spread);
      d.current_x = clip16(int'(d.desired_x) + $urandom_range(0, 2 * spread) - spread);
      d.current_y = clip16(int'(d.desired_y) + $urandom_range(0, 2 * spread) - spread);
      d.current_z = clip16(int'(d.desired_z) + $urandom_range(0, 2 * spread) - spread);
      if ($urandom_range(0, 3) == 0)
        d.current_w = -d.current_w;
    end
    return d;
  endfunction

  typedef struct {
    qoe_pkg::in_data_t  d;
    bit                 known;
    qoe_pkg::out_data_t want;
  } dir_row_t;

  localparam logic signed [15:0] ONE  = 16'sd16384;
  localparam logic signed [15:0] HALF = 16'sd11585;
  localparam logic signed [15:0] PMAX = 16'sd32767;
  localparam logic signed [15:0] NMAX = -16'sd32768;
  localparam qoe_pkg::out_data_t ZERO_ERR = '{error_x: '0, error_y: '0, error_z: '0,
                                              below_limit: 1'b1};
  localparam qoe_pkg::out_data_t NONE     = '0;

  dir_row_t dir_rows [20] = '{
    // identical orientations
    '{'{ONE, 0, 0, 0, ONE, 0, 0, 0}, 1'b1, ZERO_ERR},
    // zero quaternions
    '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ZERO_ERR},
    '{'{0, 0, 0, 0, ONE, HALF, 0, 0}, 1'b1, ZERO_ERR},
    // same rotation, opposite sign: scalar part folds positive
    '{'{-ONE, 0, 0, 0, ONE, 0, 0, 0}, 1'b1, ZERO_ERR},
    '{'{HALF, 0, HALF, 0, -HALF, 0, -HALF, 0}, 1'b1, ZERO_ERR},
    // quarter turns about each axis
    '{'{HALF, HALF, 0, 0, ONE, 0, 0, 0}, 1'b0, NONE},
    '{'{HALF, 0, HALF, 0, ONE, 0, 0, 0}, 1'b0, NONE},
    '{'{HALF, 0, 0, HALF, ONE, 0, 0, 0}, 1'b0, NONE},
    '{'{ONE, 0, 0, 0, HALF, 0, 0, -HALF}, 1'b0, NONE},
    // half turns: zero scalar part
    '{'{0, ONE, 0, 0, ONE, 0, 0, 0}, 1'b0, NONE},
    '{'{0, 0, 0, ONE, ONE, 0, 0, 0}, 1'b0, NONE},
    // tiny rotations around the limit
    '{'{ONE, 1, 0, 0, ONE, 0, 0, 0}, 1'b0, NONE},
    '{'{ONE, 16, -16, 16, ONE, 0, 0, 0}, 1'b0, NONE},
    // non-unit inputs
    '{'{100, 3, 0, 0, 100, 0, 0, 0}, 1'b0, NONE},
    '{'{1, 0, 0, 0, 0, 1, 0, 0}, 1'b0, NONE},
    // field extremes
    '{'{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1'b0, NONE},
    '{'{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX}, 1'b0, NONE},
    '{'{PMAX, NMAX, PMAX, NMAX, NMAX, PMAX, NMAX, PMAX}, 1'b0, NONE},
    '{'{0, NMAX, NMAX, NMAX, PMAX, 0, 0, 0}, 1'b0, NONE},
    '{'{NMAX, PMAX, 0, 0, 0, 0, PMAX, NMAX}, 1'b0, NONE}
  };

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [LIMIT_W-1:0] limits [4];
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    norm_limit  = '0;
    fail_count  = 0;
    words_sent  = 0;
    words_checked = 0;
    below_count = 0;
    idle_cycles = 0;
    no_gaps     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of the limit is zero
    foreach (dir_rows[i])
      send_pair(dir_rows[i].d, dir_rows[i].known, dir_rows[i].want);
    drain();

    write_limit(10'd1023);
    foreach (dir_rows[i])
      send_pair(dir_rows[i].d, dir_rows[i].known, dir_rows[i].want);
    drain();

    limits = '{10'd0, 10'd1023, 10'd37, 10'($urandom_range(1, 1022))};
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_pair(random_pair(), 1'b0, NONE);
        // sender holds off until the pipeline is empty
        if (n == N_RANDOM / 8) drain();
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d quaternion pairs, checked %0d result words (%0d below limit)",
             words_sent, words_checked, below_count);
    $display("limit settings: reset 0, 1023, 0, 1023, 37 and %0d", limits[3]);
    if (fail_count == 0 && pending_errors.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
